[hdl/csc_pkg.sv]
// Shared types, constants and keyword table for the C syntax classifier.
`default_nettype none

package csc_pkg;

   localparam int CSC_LOOKAHEAD   = 9;
   localparam int CSC_KW_SLOTS    = 32;
   localparam int CSC_KW_MAX_LEN  = 8;
   localparam int CSC_KW_TOTAL    = 23;
   localparam int CSC_KW_BYTES    = 8;
   localparam int CSC_QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      CLS_NORMAL  = 3'd0,
      CLS_COMMENT = 3'd1,
      CLS_BLOCK   = 3'd2,
      CLS_KW1     = 3'd3,
      CLS_KW2     = 3'd4,
      CLS_STRING  = 3'd5,
      CLS_NUMBER  = 3'd6
   } csc_class_type;

   typedef enum logic [1:0] {
      CSR_HIGHLIGHT_ON = 2'd0,
      CSR_NUMBER_HL    = 2'd1,
      CSR_STRING_HL    = 2'd2
   } csc_csr_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       char_present;
      logic       row_first;
      logic       row_last;
      logic       open_comment_in;
   } csc_req_type;

   typedef struct packed {
      logic [7:0] char_value;
      logic       char_valid;
      logic [2:0] char_class;
      logic       row_done;
      logic       open_comment_out;
   } csc_rsp_type;

   typedef struct packed {
      logic highlight_on;
      logic number_highlight;
      logic string_highlight;
   } csc_cfg_type;

   // keyword text, first character in the top byte, zero padded
   function automatic logic [63:0] kw_text(input int j);
      logic [63:0] t;
      t = 64'h0;
      case (j)
         0:  t = {"switch", 16'h0};
         1:  t = {"if", 48'h0};
         2:  t = {"while", 24'h0};
         3:  t = {"for", 40'h0};
         4:  t = {"break", 24'h0};
         5:  t = "continue";
         6:  t = {"return", 16'h0};
         7:  t = {"else", 32'h0};
         8:  t = {"struct", 16'h0};
         9:  t = {"union", 24'h0};
         10: t = {"typedef", 8'h0};
         11: t = {"static", 16'h0};
         12: t = {"enum", 32'h0};
         13: t = {"class", 24'h0};
         14: t = {"case", 32'h0};
         15: t = {"int", 40'h0};
         16: t = {"long", 32'h0};
         17: t = {"double", 16'h0};
         18: t = {"float", 24'h0};
         19: t = {"char", 32'h0};
         20: t = "unsigned";
         21: t = {"signed", 16'h0};
         22: t = {"void", 32'h0};
         default: t = 64'h0;
      endcase
      return t;
   endfunction

   function automatic logic [3:0] kw_len(input int j);
      logic [3:0] n;
      n = 4'd0;
      case (j)
         1:                   n = 4'd2;
         3, 15:               n = 4'd3;
         7, 12, 14, 16, 19, 22: n = 4'd4;
         2, 4, 9, 13, 18:     n = 4'd5;
         0, 6, 8, 11, 17, 21: n = 4'd6;
         10:                  n = 4'd7;
         5, 20:               n = 4'd8;
         default:             n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] kw_byte(input int j, input int k);
      logic [63:0] t;
      t = kw_text(j);
      return t[63-8*k -: 8];
   endfunction

   function automatic csc_class_type kw_kind(input int j);
      return (j < 15) ? CLS_KW1 : CLS_KW2;
   endfunction

endpackage

`default_nettype wire

[hdl/c_source_syntax_classifier.sv]
// Top level of the C syntax classifier: config registers, front queue, back end.
//
//   channel | direction | handshake          | beat
//   req_    | in        | req_valid/req_stall | csc_req_type, one row item
//   rsp_    | out       | rsp_valid/rsp_stall | csc_rsp_type, one classified byte
//   csr_    | in        | csr_valid/csr_ready | csr_index, csr_data (1 bit)
//
// Streaming bytes enter the window from the queue; a byte's result leaves once the
// window holds LOOKAHEAD bytes counting it, i.e. LOOKAHEAD-1 bytes behind it. A row
// end drains the window, one result per cycle while rsp_stall is low; the front
// queue keeps taking beats meanwhile until it fills.
// Reset is synchronous, clears control state and sets the config registers to 1.
// rsp_stall holds the result register and backs up the queue into req_stall.
`default_nettype none

module c_source_syntax_classifier
   import csc_pkg::*;
#(
   parameter int LOOKAHEAD = CSC_LOOKAHEAD
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire csc_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output csc_rsp_type      rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic        csr_data
);

   csc_cfg_type cfg_ff, cfg_in;
   logic        q_valid, q_pop;
   csc_req_type q_data;

   // config writes always complete; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HIGHLIGHT_ON: cfg_in.highlight_on     = csr_data;
            CSR_NUMBER_HL:    cfg_in.number_highlight = csr_data;
            CSR_STRING_HL:    cfg_in.string_highlight = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{highlight_on: 1'b1, number_highlight: 1'b1, string_highlight: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   csc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   csc_back #(.LOOKAHEAD(LOOKAHEAD)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[hdl/csc_front.sv]
// Front end: accepts request beats, drops no-op items and queues the rest.
`default_nettype none

module csc_front
   import csc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire csc_req_type req_data,
   output logic             q_valid,
   output csc_req_type      q_data,
   input  wire logic        q_pop
);

   localparam int PTR_W = $clog2(CSC_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(CSC_QUEUE_DEPTH + 1);

   csc_req_type      mem_ff [CSC_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             take, push;

   assign req_stall = (cnt_ff == CNT_W'(CSC_QUEUE_DEPTH));
   assign take      = req_valid && !req_stall;
   // an item with no byte, no row start and no row end does nothing
   assign push      = take && (req_data.char_present || req_data.row_first ||
                               req_data.row_last);
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push  ? PTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = q_pop ? PTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = CNT_W'(cnt_ff + CNT_W'(push) - CNT_W'(q_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= req_data;
      end
   end

endmodule

`default_nettype wire

[hdl/csc_back.sv]
// Back end: byte window, head classifier, row flush and result register.
`default_nettype none

module csc_back
   import csc_pkg::*;
#(
   parameter int LOOKAHEAD = CSC_LOOKAHEAD
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire csc_cfg_type cfg,
   input  wire logic        q_valid,
   input  wire csc_req_type q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output csc_rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(LOOKAHEAD + 1);
   localparam int PAD_N = CSC_KW_BYTES + 1;

   typedef struct packed {
      logic          ibc;
      logic [1:0]    quote;
      logic          after_sep;
      csc_class_type prev_class;
      logic [2:0]    run_rem;
      csc_class_type run_class;
      logic          rest_comment;
   } scan_type;

   function automatic scan_type restart(input logic ibc);
      scan_type s;
      s.ibc          = ibc;
      s.quote        = 2'd0;
      s.after_sep    = 1'b1;
      s.prev_class   = CLS_NORMAL;
      s.run_rem      = 3'd0;
      s.run_class    = CLS_NORMAL;
      s.rest_comment = 1'b0;
      return s;
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      logic r;
      r = 1'b0;
      case (c)
         8'd0, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, " ",
         ",", ".", "(", ")", "+", "-", "/", "*", "=", "~", "%",
         "<", ">", "[", "]", ";": r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   logic [7:0]       win_ff [LOOKAHEAD];
   logic [7:0]       win_in [LOOKAHEAD];
   logic [7:0]       win_v  [LOOKAHEAD];
   logic [7:0]       pad    [PAD_N];
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_b, cnt_v;
   scan_type         st_ff, st_in, st_b, st_c;
   logic             flush_ff, flush_in;
   logic             rsp_valid_ff, rsp_valid_in;
   csc_rsp_type      rsp_data_ff, rsp_data_in;

   logic             adv, push_byte;
   logic             emit_norm, emit_empty, start_fl, emit_fl, emit_head, done;
   csc_class_type    cls;
   logic             kw_hit, m, s;
   csc_class_type    kw_k;
   logic [3:0]       kw_l;
   logic [7:0]       c;
   logic             p_ss, p_sa, p_as;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = q_valid && !flush_ff && adv;
   assign push_byte = !flush_ff && q_data.char_present;

   // view of the window with the incoming byte appended
   always_comb begin
      if (!flush_ff && q_data.row_first) begin
         st_b  = restart(q_data.open_comment_in);
         cnt_b = '0;
      end else begin
         st_b  = st_ff;
         cnt_b = cnt_ff;
      end
      for (int k = 0; k < LOOKAHEAD; k++) begin
         win_v[k] = (push_byte && cnt_b == CNT_W'(k)) ? q_data.char_byte : win_ff[k];
      end
      cnt_v = CNT_W'(cnt_b + CNT_W'(push_byte));
   end

   for (genvar g = 0; g < PAD_N; g++) begin : g_pad
      if (g < LOOKAHEAD) begin : g_in
         assign pad[g] = win_v[g];
      end else begin : g_out
         assign pad[g] = 8'h00;
      end
   end

   // keyword match against the fixed table, lowest slot wins
   always_comb begin
      kw_hit = 1'b0;
      kw_k   = CLS_NORMAL;
      kw_l   = 4'd0;
      m      = 1'b0;
      s      = 1'b0;
      for (int j = CSC_KW_TOTAL - 1; j >= 0; j--) begin
         if (j < CSC_KW_SLOTS && int'(kw_len(j)) <= CSC_KW_MAX_LEN) begin
            m = 1'b1;
            for (int k = 0; k < CSC_KW_BYTES; k++) begin
               if (k < int'(kw_len(j))) begin
                  if (!(k < int'(cnt_v) && pad[k] == kw_byte(j, k))) m = 1'b0;
               end
            end
            s = (int'(kw_len(j)) < int'(cnt_v)) ? is_sep(pad[kw_len(j)]) : flush_ff;
            if (m && s) begin
               kw_hit = 1'b1;
               kw_k   = kw_kind(j);
               kw_l   = kw_len(j);
            end
         end
      end
   end

   // head classifier
   always_comb begin
      c    = win_v[0];
      p_ss = (cnt_v >= CNT_W'(2)) && win_v[0] == "/" && win_v[1] == "/";
      p_sa = (cnt_v >= CNT_W'(2)) && win_v[0] == "/" && win_v[1] == "*";
      p_as = (cnt_v >= CNT_W'(2)) && win_v[0] == "*" && win_v[1] == "/";
      st_c = st_b;
      cls  = CLS_NORMAL;
      if (st_b.run_rem != 3'd0) begin
         st_c.run_rem = 3'(st_b.run_rem - 3'd1);
         cls = st_b.run_class;
      end else if (st_b.rest_comment) begin
         cls = CLS_COMMENT;
      end else if (!cfg.highlight_on) begin
         cls = CLS_NORMAL;
      end else if (st_b.quote == 2'd0 && !st_b.ibc && p_ss) begin
         st_c.rest_comment = 1'b1;
         cls = CLS_COMMENT;
      end else if (st_b.quote == 2'd0 && st_b.ibc) begin
         if (p_as) begin
            st_c.run_class = CLS_BLOCK;
            st_c.run_rem   = 3'd1;
            st_c.ibc       = 1'b0;
            st_c.after_sep = 1'b1;
         end
         cls = CLS_BLOCK;
      end else if (st_b.quote == 2'd0 && p_sa) begin
         st_c.run_class = CLS_BLOCK;
         st_c.run_rem   = 3'd1;
         st_c.ibc       = 1'b1;
         cls = CLS_BLOCK;
      end else if (cfg.string_highlight && st_b.quote != 2'd0) begin
         if (c == "\\" && cnt_v > CNT_W'(1)) begin
            st_c.run_class = CLS_STRING;
            st_c.run_rem   = 3'd1;
         end else begin
            if ((st_b.quote == 2'd1 && c == "\"") || (st_b.quote == 2'd2 && c == "'"))
               st_c.quote = 2'd0;
            st_c.after_sep = 1'b1;
         end
         cls = CLS_STRING;
      end else if (cfg.string_highlight && c == "\"") begin
         st_c.quote = 2'd1;
         cls = CLS_STRING;
      end else if (cfg.string_highlight && c == "'") begin
         st_c.quote = 2'd2;
         cls = CLS_STRING;
      end else if (cfg.number_highlight &&
                   ((c >= "0" && c <= "9" && (st_b.after_sep || st_b.prev_class == CLS_NUMBER))
                    || (c == "." && st_b.prev_class == CLS_NUMBER))) begin
         st_c.after_sep = 1'b0;
         cls = CLS_NUMBER;
      end else if (st_b.after_sep && kw_hit) begin
         st_c.run_class = kw_k;
         st_c.run_rem   = 3'(kw_l - 4'd1);
         st_c.after_sep = 1'b0;
         cls = kw_k;
      end else begin
         st_c.after_sep = is_sep(c);
         cls = CLS_NORMAL;
      end
      st_c.prev_class = cls;
   end

   // sequencing of window, row state and result register
   always_comb begin
      emit_norm  = q_pop && q_data.char_present && !q_data.row_last &&
                   cnt_v == CNT_W'(LOOKAHEAD);
      emit_empty = q_pop && q_data.row_last && cnt_v == '0;
      start_fl   = q_pop && q_data.row_last && cnt_v != '0;
      emit_fl    = flush_ff && adv;
      emit_head  = emit_norm || emit_fl;
      done       = emit_fl && cnt_v == CNT_W'(1);

      win_in       = win_ff;
      cnt_in       = cnt_ff;
      st_in        = st_ff;
      flush_in     = flush_ff;
      rsp_valid_in = adv ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (emit_head) begin
         for (int k = 0; k < LOOKAHEAD - 1; k++) win_in[k] = win_v[k+1];
         win_in[LOOKAHEAD-1] = win_v[LOOKAHEAD-1];
         cnt_in   = CNT_W'(cnt_v - CNT_W'(1));
         st_in    = done ? restart(st_c.ibc) : st_c;
         flush_in = emit_fl && !done;
         rsp_valid_in                 = 1'b1;
         rsp_data_in.char_value       = win_v[0];
         rsp_data_in.char_valid       = 1'b1;
         rsp_data_in.char_class       = cls;
         rsp_data_in.row_done         = done;
         rsp_data_in.open_comment_out = done && cfg.highlight_on && st_c.ibc;
      end else if (emit_empty) begin
         cnt_in = '0;
         st_in  = restart(st_b.ibc);
         rsp_valid_in                 = 1'b1;
         rsp_data_in.char_value       = 8'h00;
         rsp_data_in.char_valid       = 1'b0;
         rsp_data_in.char_class       = CLS_NORMAL;
         rsp_data_in.row_done         = 1'b1;
         rsp_data_in.open_comment_out = cfg.highlight_on && st_b.ibc;
      end else if (q_pop) begin
         win_in   = win_v;
         cnt_in   = cnt_v;
         st_in    = st_b;
         flush_in = start_fl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         st_ff        <= restart(1'b0);
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         st_ff        <= st_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

[hdl/csc_checker.sv]
// Port-level checks for the C syntax classifier, bound to the top level.
`default_nettype none

module csc_checker
   import csc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire csc_req_type req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire csc_rsp_type rsp_data,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [1:0]  csr_index,
   input wire logic        csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_open_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.row_done |-> !rsp_data.open_comment_out)
      else $error("open comment flag outside row end");

   a_empty_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.char_valid |->
         rsp_data.row_done && rsp_data.char_class == CLS_NORMAL &&
         rsp_data.char_value == 8'h00)
      else $error("bad empty row beat");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.char_class != 3'd7)
      else $error("class code out of range");

endmodule

bind c_source_syntax_classifier csc_checker u_csc_checker (.*);

`default_nettype wire
